// ===== hdl/gn3_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the 3d gradient noise block
package gn3_pkg;

    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_PERM  = 2'd1,
        OP_GRAD  = 2'd2
    } opcode_t;

    localparam int PERM_W    = 9;
    localparam int GRAD_W    = 16;
    localparam int COORD_W   = 28;
    localparam int OUT_W     = 24;
    localparam int FRAC_W    = 16;
    localparam int T_W       = 31;
    localparam int SMOOTH_W  = 17;
    localparam int PROD_W    = 33;
    localparam int DOT_W     = 36;
    localparam int OUT_DEPTH = 16;

    // 10000.0 in q.16
    localparam logic [T_W-1:0] COORD_OFFSET = 31'd655360000;
    // 3.0 in q.16
    localparam logic [17:0] SMOOTH_THREE = 18'd196608;

endpackage

// ===== hdl/gn3_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/gn3_lerp.sv =====
`timescale 1ns / 1ps
// two-stage linear interpolation a + s*(b-a) with rounding
module gn3_lerp
    import gn3_pkg::*;
(
    input  logic                       clk,
    input  logic [SMOOTH_W-1:0]        s,
    input  logic signed [DOT_W-1:0]    a,
    input  logic signed [DOT_W-1:0]    b,
    output logic signed [DOT_W-1:0]    y
);

    localparam int DIFF_W = DOT_W + 1;
    localparam int LO_W   = 19;
    localparam int HI_W   = DIFF_W - LO_W;
    localparam int PLO_W  = SMOOTH_W + 1 + LO_W + 1;
    localparam int PHI_W  = SMOOTH_W + 1 + HI_W;
    localparam int FULL_W = 56;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [SMOOTH_W:0]   sv;
    logic signed [HI_W-1:0]     hi;
    logic signed [LO_W:0]       lo;
    logic signed [PLO_W-1:0]    p_lo_next;
    logic signed [PHI_W-1:0]    p_hi_next;
    logic signed [PLO_W-1:0]    p_lo_reg;
    logic signed [PHI_W-1:0]    p_hi_reg;
    logic signed [DOT_W-1:0]    a_reg;
    logic signed [FULL_W-1:0]   full;
    logic signed [FULL_W-1:0]   shifted;
    logic signed [DOT_W-1:0]    y_next;
    logic signed [DOT_W-1:0]    y_reg;

    always_comb
    begin
        diff      = DIFF_W'(b) - DIFF_W'(a);
        sv        = $signed({1'b0, s});
        hi        = $signed(diff[DIFF_W-1:LO_W]);
        lo        = $signed({1'b0, diff[LO_W-1:0]});
        p_lo_next = PLO_W'(sv) * PLO_W'(lo);
        p_hi_next = PHI_W'(sv) * PHI_W'(hi);
    end

    // split product recombined, then rounded floor by 2^16
    always_comb
    begin
        full    = (FULL_W'(p_hi_reg) <<< LO_W) + FULL_W'(p_lo_reg);
        shifted = (full + FULL_W'(32768)) >>> FRAC_W;
        y_next  = a_reg + DOT_W'(shifted);
    end

    always_ff @(posedge clk)
    begin
        p_lo_reg <= p_lo_next;
        p_hi_reg <= p_hi_next;
        a_reg    <= a;
        y_reg    <= y_next;
    end

    assign y = y_reg;

endmodule

// ===== hdl/gn3_fifo.sv =====
`timescale 1ns / 1ps
// result queue between the noise pipeline and the output channel
module gn3_fifo
    import gn3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [OUT_W-1:0] push_data,
    input  logic             pop,
    output logic             valid,
    output logic [OUT_W-1:0] data
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [OUT_W-1:0] mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign valid = (cnt_reg != '0);
    assign data  = mem_reg[rd_ptr_reg];

endmodule

// ===== hdl/gradient_noise_3d.sv =====
`timescale 1ns / 1ps
// top level of the 3d gradient noise block
//
// input channel s_*: s_tuser carries the opcode (query, permutation write or
// gradient write), s_tdata the table entry fields and the query point.
// writes must load both tables before a query reads them. TABLE_SIZE must be
// a power of two; all table indexes wrap modulo TABLE_SIZE.
// output channel m_*: one noise value in signed q7.16 for each query; write
// items give no result.
// throughput: one item per clock while s_tready is high. a query passes two
// permutation lookups, one gradient lookup, the dot products and three
// interpolation levels before it reaches the result queue, and can leave on
// the next cycle. each table lookup level has its own ram copies, written
// at the stage where queries read them, so items keep their order.
// a 16-entry result queue backs the pipeline; s_tready drops once 16 queries
// are in flight or waiting, so a stalled receiver loses nothing.
// reset empties the pipeline and the queue; table contents are kept and are
// undefined until written.
module gradient_noise_3d
    import gn3_pkg::*;
#(
    parameter int TABLE_SIZE = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, perm_value, grad_x, grad_y, grad_z, x_coord, y_coord, z_coord
    input  logic [151:0] s_tdata,
    // opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // noise_value
    output logic [23:0]  m_tdata
);

    localparam int AW    = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int NQ    = 12;

    // input unpacking
    logic [7:0]                 entry_index;
    logic [PERM_W-1:0]          perm_value;
    logic [3*GRAD_W-1:0]        grad_in;
    logic signed [COORD_W-1:0]  coord_in [3];

    assign entry_index = s_tdata[7:0];
    assign perm_value  = s_tdata[16:8];
    assign grad_in     = s_tdata[64:17];
    assign coord_in[0] = $signed(s_tdata[92:65]);
    assign coord_in[1] = $signed(s_tdata[120:93]);
    assign coord_in[2] = $signed(s_tdata[148:121]);

    logic accept;
    logic pop;
    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;
    logic push;
    logic [OUT_W-1:0] push_data;

    assign s_tready = (pend_reg < CNT_W'(OUT_DEPTH));
    assign accept   = s_tvalid && s_tready;

    // item valid bits for the table stages and query bits down the pipe
    logic [3:1]  vld_reg;
    logic [NQ:1] qry_reg;

    // stage 1
    logic [1:0]                s1_op_reg;
    logic [AW-1:0]             s1_idx_reg;
    logic [PERM_W-1:0]         s1_pval_reg;
    logic [3*GRAD_W-1:0]       s1_grad_reg;
    logic signed [COORD_W-1:0] s1_coord_reg [3];

    logic [T_W-1:0]    t1 [3];
    logic [AW-1:0]     cell1 [3];
    logic [FRAC_W-1:0] frac1 [3];

    // stage 2
    logic [1:0]          s2_op_reg;
    logic [AW-1:0]       s2_idx_reg;
    logic [PERM_W-1:0]   s2_pval_reg;
    logic [3*GRAD_W-1:0] s2_grad_reg;
    logic [AW-1:0]       s2_cell_reg [3];
    logic [FRAC_W-1:0]   s2_frac_reg [3];
    logic [31:0]         s2_f2_reg [3];

    // stage 3
    logic [1:0]          s3_op_reg;
    logic [AW-1:0]       s3_idx_reg;
    logic [3*GRAD_W-1:0] s3_grad_reg;
    logic [AW-1:0]       s3_cell_reg [3];
    logic [FRAC_W-1:0]   s3_frac_reg [3];
    logic [49:0]         s3_p_reg [3];

    // stage 4 and on
    logic [FRAC_W-1:0]         s4_frac_reg [3];
    logic [SMOOTH_W-1:0]       s4_s_reg [3];
    logic signed [PROD_W-1:0]  s5_prod_reg [8][3];
    logic [SMOOTH_W-1:0]       s5_s_reg [3];
    logic signed [DOT_W-1:0]   s6_dot_reg [8];
    logic [SMOOTH_W-1:0]       s6_s_reg [3];
    logic [SMOOTH_W-1:0]       s7_sy_reg;
    logic [SMOOTH_W-1:0]       s7_sz_reg;
    logic [SMOOTH_W-1:0]       s8_sy_reg;
    logic [SMOOTH_W-1:0]       s8_sz_reg;
    logic [SMOOTH_W-1:0]       s9_sz_reg;
    logic [SMOOTH_W-1:0]       s10_sz_reg;

    // table copies
    logic [PERM_W-1:0]   pa_rdata [2];
    logic [AW-1:0]       pa_raddr [2];
    logic [PERM_W-1:0]   pb_rdata [4];
    logic [AW-1:0]       pb_raddr [4];
    logic [3*GRAD_W-1:0] gd_rdata [8];
    logic [AW-1:0]       gd_raddr [8];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t1[k]    = (T_W'(s1_coord_reg[k]) <<< 1) + COORD_OFFSET;
            cell1[k] = t1[k][FRAC_W +: AW];
            frac1[k] = t1[k][FRAC_W-1:0];
        end
        pa_raddr[0] = cell1[0];
        pa_raddr[1] = cell1[0] + AW'(1);
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pb_raddr[i] = AW'(pa_rdata[i % 2]) + s2_cell_reg[1] + AW'(i / 2);
        end
        for (int i = 0; i < 8; i++)
        begin
            gd_raddr[i] = AW'(pb_rdata[i % 4]) + s3_cell_reg[2] + AW'(i / 4);
        end
    end

    for (genvar i = 0; i < 2; i++)
    begin : g_perm_a
        gn3_ram #(
            .WIDTH(PERM_W),
            .DEPTH(TABLE_SIZE)
        ) u_ram (
            .clk  (clk),
            .we   (vld_reg[1] && (s1_op_reg == OP_PERM)),
            .waddr(s1_idx_reg),
            .wdata(s1_pval_reg),
            .raddr(pa_raddr[i]),
            .rdata(pa_rdata[i])
        );
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_perm_b
        gn3_ram #(
            .WIDTH(PERM_W),
            .DEPTH(TABLE_SIZE)
        ) u_ram (
            .clk  (clk),
            .we   (vld_reg[2] && (s2_op_reg == OP_PERM)),
            .waddr(s2_idx_reg),
            .wdata(s2_pval_reg),
            .raddr(pb_raddr[i]),
            .rdata(pb_rdata[i])
        );
    end

    for (genvar i = 0; i < 8; i++)
    begin : g_grad
        gn3_ram #(
            .WIDTH(3 * GRAD_W),
            .DEPTH(TABLE_SIZE)
        ) u_ram (
            .clk  (clk),
            .we   (vld_reg[3] && (s3_op_reg == OP_GRAD)),
            .waddr(s3_idx_reg),
            .wdata(s3_grad_reg),
            .raddr(gd_raddr[i]),
            .rdata(gd_rdata[i])
        );
    end

    // smoothstep and dot products
    logic [49:0]               p_next [3];
    logic [SMOOTH_W-1:0]       s_next [3];
    logic signed [SMOOTH_W-1:0] r_sel [3];
    logic signed [PROD_W-1:0]  prod_next [8][3];
    logic signed [DOT_W-1:0]   dot_next [8];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p_next[k] = 50'(s2_f2_reg[k]) * 50'(SMOOTH_THREE - {1'b0, s2_frac_reg[k], 1'b0});
            s_next[k] = SMOOTH_W'((s3_p_reg[k] + 50'd2147483648) >> 32);
        end
        for (int c = 0; c < 8; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                r_sel[k] = $signed({((c >> k) & 1) != 0, s4_frac_reg[k]});
                prod_next[c][k] = PROD_W'($signed(gd_rdata[c][k*GRAD_W +: GRAD_W]))
                                  * PROD_W'(r_sel[k]);
            end
            dot_next[c] = DOT_W'(s5_prod_reg[c][0]) + DOT_W'(s5_prod_reg[c][1])
                          + DOT_W'(s5_prod_reg[c][2]);
        end
    end

    // interpolation tree
    logic signed [DOT_W-1:0] lx_y [4];
    logic signed [DOT_W-1:0] ly_y [2];
    logic signed [DOT_W-1:0] lz_y;

    for (genvar i = 0; i < 4; i++)
    begin : g_lerp_x
        gn3_lerp u_lerp (
            .clk(clk),
            .s  (s6_s_reg[0]),
            .a  (s6_dot_reg[2*i]),
            .b  (s6_dot_reg[2*i+1]),
            .y  (lx_y[i])
        );
    end

    for (genvar i = 0; i < 2; i++)
    begin : g_lerp_y
        gn3_lerp u_lerp (
            .clk(clk),
            .s  (s8_sy_reg),
            .a  (lx_y[2*i]),
            .b  (lx_y[2*i+1]),
            .y  (ly_y[i])
        );
    end

    gn3_lerp u_lerp_z (
        .clk(clk),
        .s  (s10_sz_reg),
        .a  (ly_y[0]),
        .b  (ly_y[1]),
        .y  (lz_y)
    );

    // scale by 1.5, drop 14 fraction bits with rounding, and saturate
    logic signed [DOT_W+2:0] scaled;
    logic signed [DOT_W+2:0] shifted;

    always_comb
    begin
        scaled  = ((DOT_W+3)'(lz_y) <<< 1) + (DOT_W+3)'(lz_y) + (DOT_W+3)'(16384);
        shifted = scaled >>> 15;
        if (shifted > (DOT_W+3)'(8388607))
        begin
            push_data = 24'h7FFFFF;
        end
        else if (shifted < -(DOT_W+3)'(8388608))
        begin
            push_data = 24'h800000;
        end
        else
        begin
            push_data = shifted[OUT_W-1:0];
        end
    end

    assign push = qry_reg[NQ];

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= s_tuser;
        s1_idx_reg  <= AW'(entry_index);
        s1_pval_reg <= perm_value;
        s1_grad_reg <= grad_in;
        for (int k = 0; k < 3; k++)
        begin
            s1_coord_reg[k] <= coord_in[k];
        end

        s2_op_reg   <= s1_op_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_pval_reg <= s1_pval_reg;
        s2_grad_reg <= s1_grad_reg;
        s3_op_reg   <= s2_op_reg;
        s3_idx_reg  <= s2_idx_reg;
        s3_grad_reg <= s2_grad_reg;
        for (int k = 0; k < 3; k++)
        begin
            s2_cell_reg[k] <= cell1[k];
            s2_frac_reg[k] <= frac1[k];
            s2_f2_reg[k]   <= 32'(frac1[k]) * 32'(frac1[k]);
            s3_cell_reg[k] <= s2_cell_reg[k];
            s3_frac_reg[k] <= s2_frac_reg[k];
            s3_p_reg[k]    <= p_next[k];
            s4_frac_reg[k] <= s3_frac_reg[k];
            s4_s_reg[k]    <= s_next[k];
            s5_s_reg[k]    <= s4_s_reg[k];
            s6_s_reg[k]    <= s5_s_reg[k];
        end
        s5_prod_reg <= prod_next;
        s6_dot_reg  <= dot_next;
        s7_sy_reg   <= s6_s_reg[1];
        s7_sz_reg   <= s6_s_reg[2];
        s8_sy_reg   <= s7_sy_reg;
        s8_sz_reg   <= s7_sz_reg;
        s9_sz_reg   <= s8_sz_reg;
        s10_sz_reg  <= s9_sz_reg;
    end

    always_comb
    begin
        pend_next = pend_reg;
        if ((accept && (s_tuser == OP_QUERY)) && !pop)
        begin
            pend_next = pend_reg + CNT_W'(1);
        end
        else if (pop && !(accept && (s_tuser == OP_QUERY)))
        begin
            pend_next = pend_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            qry_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            vld_reg  <= {vld_reg[2:1], accept};
            qry_reg  <= {qry_reg[NQ-1:1], accept && (s_tuser == OP_QUERY)};
            pend_reg <= pend_next;
        end
    end

    gn3_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .valid    (m_tvalid),
        .data     (m_tdata)
    );

    assign pop = m_tvalid && m_tready;

endmodule

// ===== tb/tb_gradient_noise_3d.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the 3d gradient noise block: table loads, directed and random queries
module tb_gradient_noise_3d;
    import gn3_pkg::*;

    localparam int TSIZE = 256;
    localparam int N_RANDOM = 515;

    typedef struct {
        opcode_t            op;
        logic [7:0]         idx;
        logic [8:0]         pval;
        logic signed [15:0] gx, gy, gz;
        logic signed [27:0] px, py, pz;
    } item_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;

    gradient_noise_3d #(.TABLE_SIZE(TSIZE)) u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    logic [8:0]  perm_copy [TSIZE];
    logic signed [15:0] grad_copy [TSIZE][3];
    logic [23:0] noise_expected [$];
    int          mismatches;
    int          n_noise_checked;
    int          n_writes;
    bit          idle_enable;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint blend(longint s, longint a, longint b);
        return a + fl_shift(s * (b - a) + 32768, 16);
    endfunction

    function automatic longint corner_grad_dot(int cx, int cy, int cz,
                                               longint rx, longint ry, longint rz);
        int h1;
        int h2;
        int gi;
        h1 = perm_copy[cx % TSIZE];
        h2 = perm_copy[(h1 + cy) % TSIZE];
        gi = (h2 + cz) % TSIZE;
        return longint'(grad_copy[gi][0]) * rx + longint'(grad_copy[gi][1]) * ry
             + longint'(grad_copy[gi][2]) * rz;
    endfunction

    function automatic logic [23:0] noise_at(logic signed [27:0] px, logic signed [27:0] py,
                                             logic signed [27:0] pz);
        longint t;
        longint f;
        longint r0 [3];
        longint r1 [3];
        longint sw [3];
        int     c0 [3];
        int     c1 [3];
        longint a0, b0, a1, b1, cc, dd, v, res;
        logic signed [27:0] p [3];
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        for (int k = 0; k < 3; k++)
        begin
            t = 2 * longint'(p[k]) + 64'd655360000;
            f = t & 64'hFFFF;
            c0[k] = int'((t >> 16) % TSIZE);
            c1[k] = (c0[k] + 1) % TSIZE;
            r0[k] = f;
            r1[k] = f - 65536;
            sw[k] = (f * f * (3 * 65536 - 2 * f) + (64'd1 << 31)) >> 32;
        end
        a0 = blend(sw[0], corner_grad_dot(c0[0], c0[1], c0[2], r0[0], r0[1], r0[2]),
                          corner_grad_dot(c1[0], c0[1], c0[2], r1[0], r0[1], r0[2]));
        b0 = blend(sw[0], corner_grad_dot(c0[0], c1[1], c0[2], r0[0], r1[1], r0[2]),
                          corner_grad_dot(c1[0], c1[1], c0[2], r1[0], r1[1], r0[2]));
        a1 = blend(sw[0], corner_grad_dot(c0[0], c0[1], c1[2], r0[0], r0[1], r1[2]),
                          corner_grad_dot(c1[0], c0[1], c1[2], r1[0], r0[1], r1[2]));
        b1 = blend(sw[0], corner_grad_dot(c0[0], c1[1], c1[2], r0[0], r1[1], r1[2]),
                          corner_grad_dot(c1[0], c1[1], c1[2], r1[0], r1[1], r1[2]));
        cc = blend(sw[1], a0, b0);
        dd = blend(sw[1], a1, b1);
        v = blend(sw[2], cc, dd);
        res = fl_shift(3 * v + 16384, 15);
        if (res > 8388607)
            res = 8388607;
        if (res < -8388608)
            res = -8388608;
        return res[23:0];
    endfunction

    // update table copies and queue the noise value for a query
    task automatic predict_item(item_t it);
        case (it.op)
            OP_QUERY: noise_expected.push_back(noise_at(it.px, it.py, it.pz));
            OP_PERM:
            begin
                perm_copy[it.idx] = it.pval;
                n_writes++;
            end
            OP_GRAD:
            begin
                grad_copy[it.idx][0] = it.gx;
                grad_copy[it.idx][1] = it.gy;
                grad_copy[it.idx][2] = it.gz;
                n_writes++;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(item_t it);
        while (idle_enable && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.pz, it.py, it.px, it.gz, it.gy, it.gx, it.pval, it.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(it);
    endtask

    function automatic item_t blank_item();
        item_t it;
        it.op = OP_QUERY;
        it.idx = '0;
        it.pval = '0;
        it.gx = '0;
        it.gy = '0;
        it.gz = '0;
        it.px = '0;
        it.py = '0;
        it.pz = '0;
        return it;
    endfunction

    function automatic logic signed [15:0] rand_grad();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic signed [27:0] rand_coord();
        case ($urandom_range(3))
            0: return 28'($urandom);
            1: return 28'(int'($urandom_range(1 << 22)) - (1 << 21));
            default: return 28'(int'($urandom_range(1 << 18)) - (1 << 17));
        endcase
    endfunction

    function automatic item_t rand_write();
        item_t it;
        it = blank_item();
        it.op = ($urandom_range(1) == 0) ? OP_PERM : OP_GRAD;
        it.idx = 8'($urandom);
        it.pval = 9'($urandom_range(511));
        it.gx = rand_grad();
        it.gy = rand_grad();
        it.gz = rand_grad();
        return it;
    endfunction

    function automatic item_t rand_query();
        item_t it;
        it = blank_item();
        it.px = rand_coord();
        it.py = rand_coord();
        it.pz = rand_coord();
        it.idx = 8'($urandom);
        it.gx = 16'($urandom);
        return it;
    endfunction

    // receiver with random stalls
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            m_tready <= !(idle_enable && $urandom_range(99) < 35);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (noise_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected noise value %h", m_tdata);
            end
            else
            begin
                logic [23:0] want;
                want = noise_expected.pop_front();
                n_noise_checked++;
                if (want !== m_tdata)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise_value mismatch: expected %h actual %h", want, m_tdata);
                end
            end
        end
    end

    typedef struct {
        logic signed [27:0] px, py, pz;
        bit                 has_value;
        logic [23:0]        value;
    } row_t;

    row_t directed_rows [] = '{
        '{28'sd0, 28'sd0, 28'sd0, 1'b1, 24'h000000},
        '{28'sd32768, 28'sd0, 28'sd0, 1'b0, 24'h0},
        '{28'sh7FFFFFF, 28'sh7FFFFFF, 28'sh7FFFFFF, 1'b0, 24'h0},
        '{28'sh8000000, 28'sh8000000, 28'sh8000000, 1'b0, 24'h0},
        '{28'sh7FFFFFF, 28'sh8000000, 28'sd0, 1'b0, 24'h0},
        '{28'sd16384, 28'sd16384, 28'sd16384, 1'b0, 24'h0},
        '{-28'sd1, -28'sd1, -28'sd1, 1'b0, 24'h0},
        '{28'sd65535, 28'sd32767, 28'sd12345, 1'b0, 24'h0},
        '{28'sh5555555, 28'shAAAAAAA, 28'sh3C3C3C3, 1'b0, 24'h0},
        '{28'sd8388608, -28'sd8388608, 28'sd7, 1'b0, 24'h0}
    };

    initial
    begin
        item_t it;
        int    n;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        idle_enable  = 1'b1;
        mismatches   = 0;
        n_noise_checked = 0;
        n_writes     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme gradients and wrapping permutation values
        for (int i = 0; i < TSIZE; i++)
        begin
            it = blank_item();
            it.op = OP_PERM;
            it.idx = 8'(i);
            it.pval = (i % 3 == 0) ? 9'd511 : ((i % 3 == 1) ? 9'd256 : 9'(i));
            send_item(it);
            it.op = OP_GRAD;
            it.gx = (i % 2) ? 16'sh8000 : 16'sh7FFF;
            it.gy = (i % 4 < 2) ? 16'sd16384 : -16'sd16384;
            it.gz = 16'sh5555 ^ 16'(i);
            send_item(it);
        end
        it = blank_item();
        it.op = opcode_t'(2'd3);
        it.idx = 8'hFF;
        it.pval = 9'h1FF;
        send_item(it);
        // a lattice point gives zero whatever the tables hold
        for (int i = 0; i < directed_rows.size(); i++)
        begin
            it = blank_item();
            it.px = directed_rows[i].px;
            it.py = directed_rows[i].py;
            it.pz = directed_rows[i].pz;
            send_item(it);
            if (directed_rows[i].has_value && noise_expected.size() > 0
                && noise_expected[$] !== directed_rows[i].value)
            begin
                mismatches++;
                $display("predicted noise %h differs from table row", noise_expected[$]);
            end
        end

        // full random reload of both tables
        for (int i = 0; i < TSIZE; i++)
        begin
            it = rand_write();
            it.idx = 8'(i);
            it.op = OP_PERM;
            send_item(it);
            it.op = OP_GRAD;
            send_item(it);
        end

        // sender holds until the pipeline is drained
        s_tvalid <= 1'b0;
        while (noise_expected.size() != 0)
            @(posedge clk);

        n = 0;
        while (n < N_RANDOM)
        begin
            idle_enable = !(n >= 150 && n < 300);
            case ($urandom_range(19))
                0, 1, 2: it = rand_write();
                3:
                begin
                    it = rand_query();
                    it.op = opcode_t'(2'd3);
                end
                default: it = rand_query();
            endcase
            send_item(it);
            n++;
        end
        s_tvalid <= 1'b0;
        idle_enable = 1'b1;
        while (noise_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d table writes and %0d noise queries with random stalls",
                 n_writes, n_noise_checked);
        if (mismatches == 0 && noise_expected.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/gn3_pkg.sv
hdl/gn3_ram.sv
hdl/gn3_lerp.sv
hdl/gn3_fifo.sv
hdl/gradient_noise_3d.sv
tb/tb_gradient_noise_3d.sv
